/* sv/nsc_pkg.sv */
// Shared types, constants and helpers for the NMEA sentence checksum checker.
package nsc_pkg;

   localparam int BufferBytesDefault = 128;
   localparam int CmdDepth           = 2;
   localparam int RspDepth           = 2;
   localparam int PosW               = 8;
   localparam int ByteW              = 8;
   localparam int KindW              = 3;
   localparam int NumKinds           = 6;
   localparam int HdrLen             = 6;

   localparam logic [ByteW-1:0] MaxBodyLenReset = 8'd75;
   localparam logic [ByteW-1:0] CharDollar      = 8'h24;
   localparam logic [ByteW-1:0] CharStar        = 8'h2A;
   localparam logic [ByteW-1:0] CharLf          = 8'h0A;
   localparam logic [ByteW-1:0] CharNul         = 8'h00;
   localparam logic [ByteW-1:0] CharZero        = 8'h30;
   localparam logic [ByteW-1:0] CharAlphaBase   = 8'h37;
   localparam logic [KindW-1:0] KindOther       = 3'd0;
   localparam logic [KindW-1:0] KindMax         = 3'd6;

   // Entry k names kind k+1; within an entry, byte [5] is the first character.
   localparam logic [NumKinds-1:0][HdrLen-1:0][ByteW-1:0] HdrTable = {
      "$GPRMA", "$GPGSA", "$GPVTG", "$GPGLL", "$GPRMC", "$GPGGA"
   };

   typedef enum logic [2:0] {
      PH_FIRST,
      PH_SCAN,
      PH_HI,
      PH_LO,
      PH_DONE,
      PH_BAD
   } phase_type;

   // One word from the front to the back: a byte to scan, or a sentence close.
   typedef struct packed {
      logic [ByteW-1:0] data;
      logic [PosW-1:0]  pos;
      logic             close;
      logic             overflow;
   } cmd_type;

   typedef struct packed {
      logic             valid;
      logic [KindW-1:0] kind;
      logic [PosW-1:0]  length;
      logic             overflow;
   } rsp_type;

   function automatic logic [ByteW-1:0] hex_char(input logic [3:0] nib);
      logic [ByteW-1:0] wide;
      wide = {4'b0000, nib};
      return (nib < 4'd10) ? (wide + CharZero) : (wide + CharAlphaBase);
   endfunction

endpackage

/* sv/nsc_fifo.sv */
// Small register queue used between the front, the back and the result port.
module nsc_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_word,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_word,
   output logic             empty
);
   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == FullCnt);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_word = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

/* sv/nsc_front.sv */
// Front end: count stored bytes and classify each byte as data or sentence close.
module nsc_front #(
   parameter int BUFFER_BYTES = 128
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   input  logic [nsc_pkg::ByteW-1:0]      req_rx_byte,
   output logic                           req_full,
   input  logic                           cmd_full,
   output logic                           cmd_push,
   output nsc_pkg::cmd_type               cmd_word
);
   import nsc_pkg::*;

   localparam logic [PosW-1:0] Limit = PosW'(BUFFER_BYTES);

   logic [PosW-1:0] pos_ff, pos_in;
   logic            is_lf, at_limit, closing;

   assign req_full = cmd_full;
   assign cmd_push = req_push && !cmd_full;
   assign is_lf    = (req_rx_byte == CharLf);
   assign at_limit = (pos_ff >= Limit);
   assign closing  = is_lf || at_limit;

   always_comb begin
      cmd_word.data     = req_rx_byte;
      cmd_word.pos      = pos_ff;
      cmd_word.close    = closing;
      cmd_word.overflow = !is_lf;
      pos_in            = pos_ff;
      if (cmd_push) begin
         // Restart the count on a close; the overflowing byte is dropped.
         pos_in = closing ? '0 : pos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

/* sv/nsc_back.sv */
// Back end: streamed checksum scan, header match and result build.
module nsc_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [nsc_pkg::ByteW-1:0] max_body_len,
   input  logic                      cmd_valid,
   input  nsc_pkg::cmd_type          cmd_word,
   output logic                      cmd_pop,
   input  logic                      rsp_full,
   output logic                      rsp_push,
   output nsc_pkg::rsp_type          rsp_word
);
   import nsc_pkg::*;

   phase_type              phase_ff, phase_in;
   logic [ByteW-1:0]       xor_ff, xor_in;
   logic [NumKinds-1:0]    match_ff, match_in;
   logic [ByteW-1:0]       hi_ff, hi_in;
   logic [ByteW-1:0]       lo_ff, lo_in;
   logic                   take, take_data, take_close;
   logic [2:0]             hdr_idx;

   // Hold a close until the result queue has room; data bytes never wait.
   assign take       = cmd_valid && (!cmd_word.close || !rsp_full);
   assign take_data  = take && !cmd_word.close;
   assign take_close = take && cmd_word.close;
   assign cmd_pop    = take;
   assign rsp_push   = take_close;
   assign hdr_idx    = 3'(HdrLen - 1) - cmd_word.pos[2:0];

   always_comb begin
      phase_in = phase_ff;
      if (take_close) begin
         phase_in = PH_FIRST;
      end else if (take_data) begin
         unique case (phase_ff)
            PH_FIRST: phase_in = (cmd_word.data == CharDollar) ? PH_SCAN : PH_BAD;
            PH_SCAN: begin
               if ((cmd_word.pos >= max_body_len) || (cmd_word.data == CharNul)) begin
                  phase_in = PH_BAD;
               end else if (cmd_word.data == CharStar) begin
                  phase_in = PH_HI;
               end
            end
            PH_HI:   phase_in = PH_LO;
            PH_LO:   phase_in = PH_DONE;
            PH_DONE: phase_in = PH_DONE;
            PH_BAD:  phase_in = PH_BAD;
            default: phase_in = PH_BAD;
         endcase
      end
   end

   always_comb begin
      xor_in   = xor_ff;
      match_in = match_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;

      rsp_word.valid    = (phase_ff == PH_DONE) &&
                          (hi_ff == hex_char(xor_ff[7:4])) &&
                          (lo_ff == hex_char(xor_ff[3:0]));
      rsp_word.kind     = KindOther;
      rsp_word.length   = cmd_word.pos;
      rsp_word.overflow = cmd_word.overflow;
      if (cmd_word.pos >= PosW'(HdrLen)) begin
         // Lowest matching header wins.
         for (int k = NumKinds - 1; k >= 0; k--) begin
            if (match_ff[k]) begin
               rsp_word.kind = KindW'(k + 1);
            end
         end
      end

      if (take_close) begin
         xor_in   = '0;
         match_in = '1;
         hi_in    = '0;
         lo_in    = '0;
      end else if (take_data) begin
         if (cmd_word.pos < PosW'(HdrLen)) begin
            for (int k = 0; k < NumKinds; k++) begin
               if (HdrTable[k][hdr_idx] != cmd_word.data) begin
                  match_in[k] = 1'b0;
               end
            end
         end
         if ((phase_ff == PH_SCAN) && (phase_in == PH_SCAN)) begin
            xor_in = xor_ff ^ cmd_word.data;
         end
         if (phase_ff == PH_HI) begin
            hi_in = cmd_word.data;
         end
         if (phase_ff == PH_LO) begin
            lo_in = cmd_word.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_FIRST;
         xor_ff   <= '0;
         match_ff <= '1;
         hi_ff    <= '0;
         lo_ff    <= '0;
      end else begin
         phase_ff <= phase_in;
         xor_ff   <= xor_in;
         match_ff <= match_in;
         hi_ff    <= hi_in;
         lo_ff    <= lo_in;
      end
   end

endmodule

/* sv/nmea_sentence_checksum_checker.sv */
// Top level of the NMEA sentence checksum checker.
//
// Usage: push received serial bytes on req_rx_byte with req_push while
// req_full is low. A line feed closes the current sentence, and so does any
// other byte that finds BUFFER_BYTES bytes already stored (that byte is
// dropped). Each close yields one result word: checksum verdict, header
// kind, stored length and an overflow flag.
// Results appear while rsp_empty is low; take one with rsp_pop.
// Write max_body_len through csr_valid/csr_max_body_len while no sentence
// is in flight; csr_ready is always high.
// Throughput: one byte per cycle while req_full is low. The front counts
// and classifies bytes into a two-word command queue; the back scans one
// command per cycle (a close waits while the result queue is full) and
// writes closes into a two-word result queue, and so lowers rsp_empty.
// When the receiver stalls, the result queue fills; the next close then
// waits at the head of the command queue, the bytes behind it pile up, and
// req_full rises once that queue holds two words.
// Reset empties both queues, clears the sentence state and sets
// max_body_len to 75.
module nmea_sentence_checksum_checker #(
   parameter int BUFFER_BYTES = nsc_pkg::BufferBytesDefault
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   input  logic [nsc_pkg::ByteW-1:0] req_rx_byte,
   output logic                      req_full,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output logic                      rsp_sentence_valid,
   output logic [nsc_pkg::KindW-1:0] rsp_sentence_kind,
   output logic [nsc_pkg::PosW-1:0]  rsp_sentence_length,
   output logic                      rsp_closed_by_overflow,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [nsc_pkg::ByteW-1:0] csr_max_body_len
);
   import nsc_pkg::*;

   logic [ByteW-1:0] max_len_ff, max_len_in;
   cmd_type          front_word, back_word;
   rsp_type          result_word, head_word;
   logic             cmd_push, cmd_full, cmd_empty, cmd_pop;
   logic             rsp_push, rsp_full;

   // Config register: always ready, write on handshake.
   assign csr_ready  = 1'b1;
   assign max_len_in = (csr_valid && csr_ready) ? csr_max_body_len : max_len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MaxBodyLenReset;
      end else begin
         max_len_ff <= max_len_in;
      end
   end

   nsc_front #(
      .BUFFER_BYTES(BUFFER_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_rx_byte(req_rx_byte),
      .req_full   (req_full),
      .cmd_full   (cmd_full),
      .cmd_push   (cmd_push),
      .cmd_word   (front_word)
   );

   // Command queue decouples byte intake from the scanner.
   nsc_fifo #(
      .WIDTH($bits(cmd_type)),
      .DEPTH(CmdDepth)
   ) u_cmd_q (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_word(front_word),
      .full     (cmd_full),
      .pop      (cmd_pop),
      .pop_word (back_word),
      .empty    (cmd_empty)
   );

   nsc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .max_body_len(max_len_ff),
      .cmd_valid   (!cmd_empty),
      .cmd_word    (back_word),
      .cmd_pop     (cmd_pop),
      .rsp_full    (rsp_full),
      .rsp_push    (rsp_push),
      .rsp_word    (result_word)
   );

   // Result queue holds finished words while the receiver stalls.
   nsc_fifo #(
      .WIDTH($bits(rsp_type)),
      .DEPTH(RspDepth)
   ) u_rsp_q (
      .clock    (clock),
      .reset    (reset),
      .push     (rsp_push),
      .push_word(result_word),
      .full     (rsp_full),
      .pop      (rsp_pop),
      .pop_word (head_word),
      .empty    (rsp_empty)
   );

   assign rsp_sentence_valid     = head_word.valid;
   assign rsp_sentence_kind      = head_word.kind;
   assign rsp_sentence_length    = head_word.length;
   assign rsp_closed_by_overflow = head_word.overflow;

endmodule

/* sv/nsc_checker.sv */
// Port-level assertions for the NMEA sentence checksum checker, with its bind.
module nsc_checker #(
   parameter int BUFFER_BYTES = nsc_pkg::BufferBytesDefault
) (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_empty,
   input logic                      rsp_sentence_valid,
   input logic [nsc_pkg::KindW-1:0] rsp_sentence_kind,
   input logic [nsc_pkg::PosW-1:0]  rsp_sentence_length,
   input logic                      rsp_closed_by_overflow
);
   import nsc_pkg::*;

   localparam logic [PosW-1:0] Limit     = PosW'(BUFFER_BYTES);
   localparam logic [PosW-1:0] MinValid  = 8'd4;

   // Drop everything on reset: no result may survive it.
   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> rsp_empty)
      else $error("result shown right after reset");

   a_length_bound: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_sentence_length <= Limit))
      else $error("sentence length beyond buffer size");

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_closed_by_overflow) |-> (rsp_sentence_length == Limit))
      else $error("overflow close without a full buffer");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_sentence_kind <= KindMax))
      else $error("sentence kind out of range");

   a_valid_min_len: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_sentence_valid) |-> (rsp_sentence_length >= MinValid))
      else $error("valid sentence too short to hold start, star and digits");

endmodule

bind nmea_sentence_checksum_checker nsc_checker #(
   .BUFFER_BYTES(BUFFER_BYTES)
) u_nsc_checker (
   .clock                 (clock),
   .reset                 (reset),
   .rsp_empty             (rsp_empty),
   .rsp_sentence_valid    (rsp_sentence_valid),
   .rsp_sentence_kind     (rsp_sentence_kind),
   .rsp_sentence_length   (rsp_sentence_length),
   .rsp_closed_by_overflow(rsp_closed_by_overflow)
);

/* bench/nmea_sentence_checksum_checker_tb.sv */
// Self-checking testbench for the NMEA checksum checker: directed table, then random lines.
module nmea_sentence_checksum_checker_tb;
   import nsc_pkg::*;

   localparam int SentenceCap  = 128;
   localparam int SettleCycles = 4;
   localparam int DrainLimit   = 20000;
   localparam int RandomBytes  = 240;
   localparam int ReportLimit  = 200;
   localparam int TimeoutLimit = 2_000_000;

   localparam logic [ByteW-1:0] CharComma = 8'h2C;
   localparam logic [ByteW-1:0] CharFill  = 8'h58;

   typedef enum logic [KindW-1:0] {
      SK_OTHER, SK_GGA, SK_RMC, SK_GLL, SK_VTG, SK_GSA, SK_RMA
   } sentence_kind_type;

   typedef enum int {SUM_NONE, SUM_UPPER, SUM_LOWER, SUM_WRONG} sum_mode_type;
   typedef enum int {CLOSE_LF, CLOSE_FULL} close_mode_type;

   // One row of the directed table: a limit write, or one line to send.
   typedef struct {
      bit             is_limit;
      logic [7:0]     limit;
      string          text;
      int             pad_to;
      sum_mode_type   sum;
      close_mode_type close_by;
      bit             typed;
      rsp_type        want;
   } stim_row_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_push;
   logic [ByteW-1:0]     req_rx_byte;
   logic                 req_full;
   logic                 rsp_empty;
   logic                 rsp_pop;
   logic                 rsp_sentence_valid;
   logic [KindW-1:0]     rsp_sentence_kind;
   logic [PosW-1:0]      rsp_sentence_length;
   logic                 rsp_closed_by_overflow;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [ByteW-1:0]     csr_max_body_len;

   // Predicted sentence state, kept in step with every accepted byte word.
   phase_type            scan_ph;
   logic [7:0]           body_limit;
   logic [7:0]           stored;
   logic [7:0]           xsum;
   logic [7:0]           hi_ch;
   logic [7:0]           lo_ch;
   logic [5:0]           hdr_alive;
   rsp_type              expected_q[$];

   logic [7:0]           line_buf[$];
   bit                   typed_armed;
   rsp_type              typed_value;
   bit                   sender_gaps;
   int                   burst_left;
   int                   hold_request;

   int                   errors;
   int                   bytes_sent;
   int                   results_seen;
   int                   valid_seen;
   int                   overflow_seen;
   int                   full_stall_cycles;
   int                   limits_written;
   logic [7:0]           kinds_seen;

   always #5 clock = ~clock;

   nmea_sentence_checksum_checker #(
      .BUFFER_BYTES(SentenceCap)
   ) DUT (
      .clock                  (clock),
      .reset                  (reset),
      .req_push               (req_push),
      .req_rx_byte            (req_rx_byte),
      .req_full               (req_full),
      .rsp_empty              (rsp_empty),
      .rsp_pop                (rsp_pop),
      .rsp_sentence_valid     (rsp_sentence_valid),
      .rsp_sentence_kind      (rsp_sentence_kind),
      .rsp_sentence_length    (rsp_sentence_length),
      .rsp_closed_by_overflow (rsp_closed_by_overflow),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_max_body_len       (csr_max_body_len)
   );

   // Header text of kind k+1, first character in the top byte.
   function automatic logic [47:0] kind_tag(input int k);
      case (k)
         0: return "$GPGGA";
         1: return "$GPRMC";
         2: return "$GPGLL";
         3: return "$GPVTG";
         4: return "$GPGSA";
         default: return "$GPRMA";
      endcase
   endfunction

   function automatic logic [7:0] hex_digit(input logic [3:0] nib, input bit upper);
      if (nib < 4'd10)
         return 8'h30 + 8'(nib);
      return (upper ? 8'h41 : 8'h61) + 8'(nib) - 8'd10;
   endfunction

   function automatic logic [7:0] printable_byte();
      logic [7:0] c;
      c = 8'($urandom_range(32, 126));
      return (c == CharStar) ? 8'h2B : c;
   endfunction

   function automatic void restart_sentence();
      scan_ph   = PH_FIRST;
      stored    = '0;
      xsum      = '0;
      hi_ch     = '0;
      lo_ch     = '0;
      hdr_alive = '1;
   endfunction

   // Advance the sentence state by one byte; return 1 with the result when it closes.
   function automatic bit predict_close(input logic [7:0] b, output rsp_type r);
      logic [47:0] tag;
      int          p;
      r = '0;
      p = stored;
      if (b != CharLf && p < SentenceCap) begin
         if (p < HdrLen) begin
            for (int k = 0; k < NumKinds; k++) begin
               tag = kind_tag(k);
               if (tag[47 - 8 * p -: 8] != b)
                  hdr_alive[k] = 1'b0;
            end
         end
         case (scan_ph)
            PH_FIRST: scan_ph = (b == CharDollar) ? PH_SCAN : PH_BAD;
            PH_SCAN: begin
               if (stored >= body_limit || b == CharNul)
                  scan_ph = PH_BAD;
               else if (b == CharStar)
                  scan_ph = PH_HI;
               else
                  xsum ^= b;
            end
            PH_HI: begin
               hi_ch   = b;
               scan_ph = PH_LO;
            end
            PH_LO: begin
               lo_ch   = b;
               scan_ph = PH_DONE;
            end
            default: ;
         endcase
         stored = stored + 8'd1;
         return 1'b0;
      end
      r.valid = (scan_ph == PH_DONE) && hi_ch == hex_digit(xsum[7:4], 1'b1)
                && lo_ch == hex_digit(xsum[3:0], 1'b1);
      r.kind = SK_OTHER;
      if (p >= HdrLen) begin
         // Walk down so the lowest matching header wins.
         for (int k = NumKinds - 1; k >= 0; k--)
            if (hdr_alive[k])
               r.kind = KindW'(k + 1);
      end
      r.length   = stored;
      r.overflow = (b != CharLf);
      restart_sentence();
      return 1'b1;
   endfunction

   function automatic stim_row_type line_row(input string text, input int pad_to,
                                             input sum_mode_type sum);
      stim_row_type row;
      row.is_limit = 1'b0;
      row.limit    = '0;
      row.text     = text;
      row.pad_to   = pad_to;
      row.sum      = sum;
      row.close_by = CLOSE_LF;
      row.typed    = 1'b0;
      row.want     = '0;
      return row;
   endfunction

   function automatic stim_row_type typed_row(input string text, input int pad_to,
                                              input sum_mode_type sum,
                                              input close_mode_type how,
                                              input bit valid,
                                              input sentence_kind_type kind,
                                              input int len, input bit ovf);
      stim_row_type row;
      row               = line_row(text, pad_to, sum);
      row.close_by      = how;
      row.typed         = 1'b1;
      row.want.valid    = valid;
      row.want.kind     = kind;
      row.want.length   = PosW'(len);
      row.want.overflow = ovf;
      return row;
   endfunction

   function automatic stim_row_type limit_row(input logic [7:0] v);
      stim_row_type row;
      row          = line_row("", 0, SUM_NONE);
      row.is_limit = 1'b1;
      row.limit    = v;
      return row;
   endfunction

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         errors++;
         if (errors <= ReportLimit)
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      end
   endfunction

   task automatic check_result(input rsp_type got);
      rsp_type want;
      results_seen++;
      if (got.valid)
         valid_seen++;
      if (got.overflow)
         overflow_seen++;
      kinds_seen[got.kind] = 1'b1;
      if (expected_q.size() == 0) begin
         errors++;
         if (errors <= ReportLimit)
            $display("%0t: result with no sentence pending: expected none, got %0d/%0d/%0d/%0d",
                     $time, got.valid, got.kind, got.length, got.overflow);
         return;
      end
      want = expected_q.pop_front();
      check_field("sentence_valid", want.valid, got.valid);
      check_field("sentence_kind", want.kind, got.kind);
      check_field("sentence_length", want.length, got.length);
      check_field("closed_by_overflow", want.overflow, got.overflow);
   endtask

   // Offer a byte; call at a rising edge, returns at the edge that took it or after a gap.
   task automatic offer_byte(input logic [7:0] b);
      bit      took;
      rsp_type r;
      req_push    <= 1'b1;
      req_rx_byte <= b;
      do begin
         @(negedge clock);
         took = !req_full;
         if (!took)
            full_stall_cycles++;
         @(posedge clock);
      end while (!took);
      bytes_sent++;
      if (predict_close(b, r)) begin
         if (typed_armed) begin
            r           = typed_value;
            typed_armed = 1'b0;
         end
         expected_q.push_back(r);
      end
      if (sender_gaps) begin
         burst_left--;
         if (burst_left <= 0) begin
            req_push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            burst_left = $urandom_range(1, 24);
         end
      end
   endtask

   task automatic send_line();
      foreach (line_buf[i])
         offer_byte(line_buf[i]);
   endtask

   // Hold the input until every predicted result is out, then let the pipe settle.
   task automatic drain_results();
      int waited;
      req_push <= 1'b0;
      waited = 0;
      while (expected_q.size() != 0 && waited < DrainLimit) begin
         @(posedge clock);
         waited++;
      end
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_limit(input logic [7:0] v);
      bit took;
      drain_results();
      csr_valid        <= 1'b1;
      csr_max_body_len <= v;
      do begin
         @(negedge clock);
         took = csr_ready;
         @(posedge clock);
      end while (!took);
      body_limit = v;
      csr_valid <= 1'b0;
      limits_written++;
   endtask

   // Append '*' and two check digits over all bytes after the first, unless SUM_NONE.
   task automatic append_checksum(input sum_mode_type mode);
      logic [7:0] x;
      x = '0;
      if (mode == SUM_NONE)
         return;
      for (int i = 1; i < line_buf.size(); i++)
         x ^= line_buf[i];
      if (mode == SUM_WRONG)
         x ^= 8'($urandom_range(1, 255));
      line_buf.push_back(CharStar);
      line_buf.push_back(hex_digit(x[7:4], mode != SUM_LOWER));
      line_buf.push_back(hex_digit(x[3:0], mode != SUM_LOWER));
   endtask

   // In table text '#' stands for NUL and '^' for 0xFF.
   task automatic build_row_line(input stim_row_type row);
      logic [7:0] c;
      line_buf.delete();
      for (int i = 0; i < row.text.len(); i++) begin
         c = row.text[i];
         if (c == "#")
            c = CharNul;
         else if (c == "^")
            c = 8'hFF;
         line_buf.push_back(c);
      end
      while (line_buf.size() < row.pad_to)
         line_buf.push_back(CharComma);
      append_checksum(row.sum);
      if (row.close_by == CLOSE_FULL) begin
         while (line_buf.size() < SentenceCap)
            line_buf.push_back(CharComma);
         line_buf.push_back(CharFill);
      end else begin
         line_buf.push_back(CharLf);
      end
   endtask

   // Mostly well-formed lines with random content; some broken, some pure noise.
   task automatic build_random_line();
      int           roll;
      int           pick;
      int           body_len;
      int           len_roll;
      int           sum_roll;
      int           cut;
      logic [47:0]  tag;
      sum_mode_type mode;
      line_buf.delete();
      roll = $urandom_range(0, 99);
      if (roll >= 90) begin
         repeat ($urandom_range(1, 20))
            line_buf.push_back(8'($urandom_range(0, 255)));
         line_buf.push_back(CharLf);
         return;
      end
      pick = $urandom_range(0, 7);
      if (pick < NumKinds) begin
         tag = kind_tag(pick);
         for (int p = 0; p < HdrLen; p++)
            line_buf.push_back(tag[47 - 8 * p -: 8]);
      end else begin
         line_buf.push_back(CharDollar);
         line_buf.push_back("G");
         line_buf.push_back("P");
         repeat (3)
            line_buf.push_back(printable_byte());
      end
      len_roll = $urandom_range(0, 99);
      if (len_roll < 80)
         body_len = $urandom_range(0, 12);
      else if (len_roll < 96)
         body_len = $urandom_range(13, 90);
      else
         body_len = $urandom_range(115, 140);
      repeat (body_len)
         line_buf.push_back(printable_byte());
      sum_roll = $urandom_range(0, 99);
      if (sum_roll < 85)
         mode = SUM_UPPER;
      else if (sum_roll < 90)
         mode = SUM_LOWER;
      else if (sum_roll < 95)
         mode = SUM_WRONG;
      else
         mode = SUM_NONE;
      append_checksum(mode);
      if (roll >= 75) begin
         case ($urandom_range(0, 2))
            0: line_buf[$urandom_range(0, line_buf.size() - 1)] = 8'($urandom_range(0, 255));
            1: begin
               cut = $urandom_range(1, line_buf.size());
               while (line_buf.size() > cut)
                  void'(line_buf.pop_back());
            end
            default: line_buf[0] = printable_byte();
         endcase
      end
      line_buf.push_back(CharLf);
   endtask

   // Result side: sample before the edge, check words taken at the edge, then
   // pick the next pop from a changing stall pattern or a requested long hold.
   initial begin : result_side
      bit      pop_seen;
      bit      empty_seen;
      bit      reset_seen;
      rsp_type got;
      int      pop_mode;
      int      mode_left;
      int      hold_left;
      int      tick;
      rsp_pop   <= 1'b0;
      mode_left = 0;
      hold_left = 0;
      tick      = 0;
      pop_mode  = 0;
      forever begin
         @(negedge clock);
         pop_seen     = rsp_pop;
         empty_seen   = rsp_empty;
         reset_seen   = reset;
         got.valid    = rsp_sentence_valid;
         got.kind     = rsp_sentence_kind;
         got.length   = rsp_sentence_length;
         got.overflow = rsp_closed_by_overflow;
         @(posedge clock);
         if (!reset_seen && pop_seen && !empty_seen)
            check_result(got);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (mode_left == 0) begin
            pop_mode  = $urandom_range(0, 2);
            mode_left = $urandom_range(50, 300);
         end
         mode_left--;
         tick++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            case (pop_mode)
               0: rsp_pop <= 1'b1;
               1: rsp_pop <= ($urandom_range(0, 2) != 0);
               default: rsp_pop <= (tick % 5 < 3);
            endcase
         end
      end
   end

   // Byte side: reset, directed table, pressure burst, then random phases.
   initial begin : byte_side
      stim_row_type stim_rows[$];
      logic [7:0]   phase_limit[6];
      int           phase_bytes;
      errors            = 0;
      bytes_sent        = 0;
      results_seen      = 0;
      valid_seen        = 0;
      overflow_seen     = 0;
      full_stall_cycles = 0;
      limits_written    = 0;
      kinds_seen        = '0;
      hold_request      = 0;
      typed_armed       = 1'b0;
      sender_gaps       = 1'b1;
      burst_left        = 1;
      reset            <= 1'b1;
      req_push         <= 1'b0;
      req_rx_byte      <= '0;
      csr_valid        <= 1'b0;
      csr_max_body_len <= MaxBodyLenReset;
      body_limit        = MaxBodyLenReset;
      restart_sentence();

      stim_rows.push_back(typed_row("", 0, SUM_NONE, CLOSE_LF, 0, SK_OTHER, 0, 0));
      stim_rows.push_back(typed_row("", 0, SUM_NONE, CLOSE_LF, 0, SK_OTHER, 0, 0));
      stim_rows.push_back(line_row("$GPGGA,123519,4807.038,N", 0, SUM_UPPER));
      stim_rows.push_back(line_row("$GPRMC,A", 0, SUM_UPPER));
      stim_rows.push_back(line_row("$GPGLL,", 0, SUM_UPPER));
      stim_rows.push_back(line_row("$GPVTG,^", 0, SUM_UPPER));
      stim_rows.push_back(line_row("$GPGSA,1,3", 0, SUM_UPPER));
      stim_rows.push_back(line_row("$GPRMA,V", 0, SUM_UPPER));
      stim_rows.push_back(typed_row("GPGSA,1", 0, SUM_NONE, CLOSE_LF, 0, SK_OTHER, 7, 0));
      stim_rows.push_back(line_row("GPGSA,1", 0, SUM_UPPER));
      stim_rows.push_back(typed_row("$GP", 0, SUM_NONE, CLOSE_LF, 0, SK_OTHER, 3, 0));
      stim_rows.push_back(typed_row("$GPGGA*", 0, SUM_NONE, CLOSE_LF, 0, SK_GGA, 7, 0));
      stim_rows.push_back(line_row("$GPGGA,Z", 0, SUM_LOWER));
      stim_rows.push_back(line_row("$GPRMC,2", 0, SUM_WRONG));
      stim_rows.push_back(typed_row("$GP#GGA", 0, SUM_UPPER, CLOSE_LF, 0, SK_OTHER, 10, 0));
      stim_rows.push_back(line_row("$GPVTG", 74, SUM_UPPER));
      stim_rows.push_back(line_row("$GPVTG", 75, SUM_UPPER));
      stim_rows.push_back(typed_row("$GPRMC", 128, SUM_NONE, CLOSE_LF, 0, SK_RMC, 128, 0));
      stim_rows.push_back(typed_row("$GPGLL", 0, SUM_NONE, CLOSE_FULL, 0, SK_GLL, 128, 1));
      stim_rows.push_back(limit_row(8'd2));
      stim_rows.push_back(typed_row("$", 0, SUM_UPPER, CLOSE_LF, 1, SK_OTHER, 4, 0));
      stim_rows.push_back(line_row("$A", 0, SUM_UPPER));
      stim_rows.push_back(limit_row(8'd1));
      stim_rows.push_back(typed_row("$", 0, SUM_UPPER, CLOSE_LF, 0, SK_OTHER, 4, 0));
      stim_rows.push_back(limit_row(8'd255));
      stim_rows.push_back(line_row("$GPGSA", 125, SUM_UPPER));

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (stim_rows[i]) begin
         if (stim_rows[i].is_limit) begin
            write_limit(stim_rows[i].limit);
         end else begin
            build_row_line(stim_rows[i]);
            typed_armed = stim_rows[i].typed;
            typed_value = stim_rows[i].want;
            send_line();
         end
      end

      phase_limit[0] = MaxBodyLenReset;
      phase_limit[1] = 8'd255;
      phase_limit[2] = 8'd2;
      phase_limit[3] = 8'($urandom_range(3, 254));
      phase_limit[4] = 8'd16;
      phase_limit[5] = 8'd128;
      for (int ph = 0; ph < 6; ph++) begin
         write_limit(phase_limit[ph]);
         sender_gaps = (ph % 2 == 0);
         if (ph == 0) begin
            // Stall the receiver while closes pour in back to back, so the
            // result and command queues fill and the input backs up.
            sender_gaps  = 1'b0;
            hold_request = 150;
            repeat (40) begin
               if ($urandom_range(0, 1) != 0)
                  offer_byte(CharDollar);
               offer_byte(CharLf);
            end
            drain_results();
            sender_gaps = 1'b1;
         end
         phase_bytes = bytes_sent;
         while (bytes_sent - phase_bytes < RandomBytes / 6) begin
            build_random_line();
            send_line();
            if ($urandom_range(0, 19) == 0)
               drain_results();
         end
      end

      drain_results();
      repeat (10) @(posedge clock);
      if (expected_q.size() != 0) begin
         $display("%0t: sentence results missing: expected %0d more, got none",
                  $time, expected_q.size());
         errors += expected_q.size();
      end
      $display("Sent %0d bytes over %0d limit settings; checked %0d sentences",
               bytes_sent, limits_written, results_seen);
      $display("(%0d valid, %0d overflow); header kinds seen (bit per kind): %b;",
               valid_seen, overflow_seen, kinds_seen[6:0]);
      $display("input held off by full for %0d cycles.", full_stall_cycles);
      if (errors == 0)
         $display("** nmea_sentence_checksum_checker: PASSED **");
      else
         $display("** nmea_sentence_checksum_checker: FAILED **");
      $finish;
   end

   initial begin : watchdog
      #(TimeoutLimit);
      $display("%0t: timeout waiting on handshakes", $time);
      $display("** nmea_sentence_checksum_checker: FAILED **");
      $finish;
   end

endmodule
